/* sv/sdw_pkg.sv */
// ----------------------------------------------------------------------------
// sdw_pkg
// Shared types and fixed constants of the strided window downsampler.
// ----------------------------------------------------------------------------
package sdw_pkg;

    // item kinds on the input stream
    typedef enum logic [1:0] {
        OP_PIX_WRITE = 2'd0,
        OP_WGT_WRITE = 2'd1,
        OP_COMPUTE   = 2'd2
    } op_t;

    // configuration register indexes
    localparam logic [2:0] REG_FACTOR = 3'd0;
    localparam logic [2:0] REG_MARGIN = 3'd1;
    localparam logic [2:0] REG_SPAN   = 3'd2;
    localparam logic [2:0] REG_SRC_W  = 3'd3;
    localparam logic [2:0] REG_SRC_H  = 3'd4;
    localparam logic [2:0] REG_DST_W  = 3'd5;
    localparam logic [2:0] REG_DST_H  = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // fixed store and arithmetic sizes
    localparam int NUM_CH    = 4;
    localparam int PIX_AW    = 16;
    localparam int ACC_W     = 64;
    localparam int RND_SHIFT = 16;
    localparam int COORD_W   = 15;   // signed source coordinate, -14 .. 15825
    localparam int CENTER_W  = 14;   // (dest + margin) * factor
    localparam int TAP_W     = 5;    // taps per row, at most 29
    localparam int K_W       = 10;   // running weight index

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ORIGIN,
        ST_ROWBASE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [4:0] factor;
        logic [7:0] margin;
        logic [4:0] span;
        logic [8:0] src_w;
        logic [8:0] src_h;
        logic [8:0] dst_w;
        logic [8:0] dst_h;
    } cfg_t;

    // read request from the tap generator to the stores
    typedef struct packed {
        logic              en;
        logic [PIX_AW-1:0] pix_addr;
    } rd_req_t;

    // sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic res_load;
        logic res_err;
    } seq_stat_t;

endpackage

/* sv/strided_window_downsampler_top.sv */
// ----------------------------------------------------------------------------
// strided_window_downsampler_top
// Strided 2-D FIR downsampler over a stored four-channel source image.
// ----------------------------------------------------------------------------
// Pixel and weight write items are accepted back to back while the block is
// idle. A compute item holds the input off while the sequencer walks the
// window through one shared four-lane multiply-accumulate unit, one tap per
// cycle, with n = 2*(span/2) - 1 taps per row; a coordinate outside the
// destination size skips the walk and gives a zero result with the error
// status. The result waits in an output register, so the next item is
// taken while it is unclaimed; a compute stalls in its last step only if
// that register is still full. Both memories come up undefined; the user
// must write every location that a compute reads, and the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module strided_window_downsampler_top
    import sdw_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_SPAN       = 16,
    parameter int CHANNEL_BITS   = 24,
    parameter int WEIGHT_BITS    = 18,
    localparam int IN_DATA_W  = ((PIX_AW + NUM_CH*CHANNEL_BITS + WEIGHT_BITS + 16 + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((NUM_CH*CHANNEL_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // store_address, in_red, in_green, in_blue, in_alpha, weight_value,
    // dest_x, dest_y, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [1:0]            s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_red, out_green, out_blue, out_alpha, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // coord_status, clipped
    output logic [1:0]            m_tuser
);

    localparam int CB        = CHANNEL_BITS;
    localparam int WB        = WEIGHT_BITS;
    localparam int WGT_DEPTH = MAX_SPAN * MAX_SPAN;
    localparam int WA_W      = $clog2(WGT_DEPTH);
    localparam int WGT_LSB   = PIX_AW + NUM_CH*CB;
    localparam int DX_LSB    = WGT_LSB + WB;
    localparam int DY_LSB    = DX_LSB + 8;

    cfg_t                  cfg_reg;
    logic                  s_accept;
    logic                  pix_we;
    logic                  wgt_we;
    logic                  go;
    logic [PIX_AW-1:0]     store_address;
    logic [7:0]            dest_x;
    logic [7:0]            dest_y;
    seq_stat_t             stat;
    rd_req_t               rd_req;
    logic [WA_W-1:0]       wgt_raddr;
    logic                  rd_valid;
    logic [NUM_CH*CB-1:0]  pix_rdata;
    logic [WB-1:0]         wgt_rdata;
    logic [NUM_CH*CB-1:0]  res_data;
    logic                  res_clip;
    logic                  out_free;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.factor <= 5'd1;
            cfg_reg.margin <= 8'd0;
            cfg_reg.span   <= 5'd2;
            cfg_reg.src_w  <= 9'd256;
            cfg_reg.src_h  <= 9'd256;
            cfg_reg.dst_w  <= 9'd256;
            cfg_reg.dst_h  <= 9'd256;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FACTOR: cfg_reg.factor <= cfg_wr_data[4:0];
                REG_MARGIN: cfg_reg.margin <= cfg_wr_data[7:0];
                REG_SPAN:   cfg_reg.span   <= cfg_wr_data[4:0];
                REG_SRC_W:  cfg_reg.src_w  <= cfg_wr_data;
                REG_SRC_H:  cfg_reg.src_h  <= cfg_wr_data;
                REG_DST_W:  cfg_reg.dst_w  <= cfg_wr_data;
                REG_DST_H:  cfg_reg.dst_h  <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    // input item decode
    assign s_tready      = stat.idle;
    assign s_accept      = s_tvalid && s_tready;
    assign store_address = s_tdata[PIX_AW-1:0];
    assign dest_x        = s_tdata[DX_LSB +: 8];
    assign dest_y        = s_tdata[DY_LSB +: 8];

    always_comb
    begin
        pix_we = 1'b0;
        wgt_we = 1'b0;
        go     = 1'b0;
        unique case (s_tuser)
            OP_PIX_WRITE: pix_we = s_accept;
            OP_WGT_WRITE: wgt_we = s_accept && ({16'b0, store_address} < 32'(WGT_DEPTH));
            OP_COMPUTE:   go     = s_accept;
            default:      ;
        endcase
    end

    sdw_seq #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_SPAN       (MAX_SPAN),
        .WA_W           (WA_W)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .go       (go),
        .dest_x   (dest_x),
        .dest_y   (dest_y),
        .out_free (out_free),
        .stat     (stat),
        .rd_req   (rd_req),
        .wgt_addr (wgt_raddr)
    );

    sdw_store #(
        .CB   (CB),
        .WB   (WB),
        .WA_W (WA_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_we    (pix_we),
        .pix_waddr (store_address),
        .pix_wdata (s_tdata[PIX_AW +: NUM_CH*CB]),
        .wgt_we    (wgt_we),
        .wgt_waddr (store_address[WA_W-1:0]),
        .wgt_wdata (s_tdata[WGT_LSB +: WB]),
        .rd_req    (rd_req),
        .wgt_raddr (wgt_raddr),
        .rd_valid  (rd_valid),
        .pix_rdata (pix_rdata),
        .wgt_rdata (wgt_rdata)
    );

    sdw_mac #(
        .CB (CB),
        .WB (WB)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (go),
        .rd_valid  (rd_valid),
        .pix_rdata (pix_rdata),
        .wgt_rdata (wgt_rdata),
        .res_data  (res_data),
        .res_clip  (res_clip)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (stat.res_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_load)
        begin
            if (stat.res_err)
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b01;
            end
            else
            begin
                m_tdata_reg <= OUT_DATA_W'(res_data);
                m_tuser_reg <= {res_clip, 1'b0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stat.res_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an unclaimed item");
`endif

endmodule

/* sv/sdw_store.sv */
// ----------------------------------------------------------------------------
// sdw_store
// Source pixel memory and filter weight memory, one write and one
// registered read per cycle each.
// ----------------------------------------------------------------------------
module sdw_store
    import sdw_pkg::*;
#(
    parameter int CB   = 24,
    parameter int WB   = 18,
    parameter int WA_W = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_we,
    input  logic [PIX_AW-1:0]      pix_waddr,
    input  logic [NUM_CH*CB-1:0]   pix_wdata,
    input  logic                   wgt_we,
    input  logic [WA_W-1:0]        wgt_waddr,
    input  logic [WB-1:0]          wgt_wdata,
    input  rd_req_t                rd_req,
    input  logic [WA_W-1:0]        wgt_raddr,
    output logic                   rd_valid,
    output logic [NUM_CH*CB-1:0]   pix_rdata,
    output logic [WB-1:0]          wgt_rdata
);

    localparam int PIX_DEPTH = 1 << PIX_AW;
    localparam int WGT_DEPTH = 1 << WA_W;

    logic [NUM_CH*CB-1:0] pix_mem [PIX_DEPTH];
    logic [WB-1:0]        wgt_mem [WGT_DEPTH];
    logic                 rd_valid_reg;

    // pixel memory
    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        pix_rdata <= pix_mem[rd_req.pix_addr];
    end

    // weight memory
    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[wgt_waddr] <= wgt_wdata;
        end
        wgt_rdata <= wgt_mem[wgt_raddr];
    end

    // read data qualifier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_req.en;
        end
    end

    assign rd_valid = rd_valid_reg;

endmodule

/* sv/sdw_mac.sv */
// ----------------------------------------------------------------------------
// sdw_mac
// Four-lane multiply-accumulate unit shared by all taps, with accumulator
// saturation and the final round and clip to the channel format.
// ----------------------------------------------------------------------------
module sdw_mac
    import sdw_pkg::*;
#(
    parameter int CB = 24,
    parameter int WB = 18
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 rd_valid,
    input  logic [NUM_CH*CB-1:0] pix_rdata,
    input  logic [WB-1:0]        wgt_rdata,
    output logic [NUM_CH*CB-1:0] res_data,
    output logic                 res_clip
);

    localparam int Q_W = ACC_W - RND_SHIFT;

    logic signed [WB-1:0] wgt;
    logic                 prod_valid_reg;
    logic [NUM_CH-1:0]    lane_clip;
    logic [NUM_CH-1:0]    acc_ok;

    assign wgt = $signed(wgt_rdata);

    // product qualifier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= rd_valid;
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        logic signed [CB-1:0]    pix;
        logic signed [CB+WB-1:0] prod_reg;
        logic signed [ACC_W-1:0] acc_reg;
        logic signed [ACC_W-1:0] acc_next;
        logic signed [ACC_W:0]   sum;
        logic signed [ACC_W-1:0] rnd;
        logic [Q_W-1:0]          q;
        logic                    q_ok;

        assign pix = $signed(pix_rdata[c*CB +: CB]);

        // multiply stage
        always_ff @(posedge clk)
        begin
            prod_reg <= pix * wgt;
        end

        // accumulate with saturation to -2^62 .. 2^62 - 1
        assign sum = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(prod_reg);

        always_comb
        begin
            if (sum[ACC_W:ACC_W-2] == 3'b000 || sum[ACC_W:ACC_W-2] == 3'b111)
            begin
                acc_next = sum[ACC_W-1:0];
            end
            else if (sum[ACC_W])
            begin
                acc_next = {2'b11, {(ACC_W-2){1'b0}}};
            end
            else
            begin
                acc_next = {2'b00, {(ACC_W-2){1'b1}}};
            end
        end

        always_ff @(posedge clk)
        begin
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end

        assign acc_ok[c] = (acc_reg[ACC_W-1] == acc_reg[ACC_W-2]);

        // round half up, then clip to the channel range
        assign rnd  = acc_reg + ACC_W'(1 << (RND_SHIFT - 1));
        assign q    = rnd[ACC_W-1:RND_SHIFT];
        assign q_ok = (&q[Q_W-1:CB-1]) || !(|q[Q_W-1:CB-1]);

        always_comb
        begin
            if (q_ok)
            begin
                res_data[c*CB +: CB] = q[CB-1:0];
            end
            else if (q[Q_W-1])
            begin
                res_data[c*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
            end
            else
            begin
                res_data[c*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
            end
        end

        assign lane_clip[c] = !q_ok;
    end

    assign res_clip = |lane_clip;

`ifndef SYNTHESIS
    // an accumulate step must leave every lane inside the saturation bounds
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && !clear |=> &acc_ok)
        else $error("accumulator left its saturation range");
`endif

endmodule

/* sv/sdw_seq.sv */
// ----------------------------------------------------------------------------
// sdw_seq
// Sequencer: works out the window origin, then walks the taps in raster
// order, one per cycle, issuing pixel and weight reads to the MAC lanes.
// ----------------------------------------------------------------------------
module sdw_seq
    import sdw_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_SPAN       = 16,
    parameter int WA_W           = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            go,
    input  logic [7:0]      dest_x,
    input  logic [7:0]      dest_y,
    input  logic            out_free,
    output seq_stat_t       stat,
    output rd_req_t         rd_req,
    output logic [WA_W-1:0] wgt_addr
);

    seq_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] u_reg, u_next;
    logic signed [COORD_W-1:0] v_reg, v_next;
    logic signed [COORD_W-1:0] u0_reg, u0_next;
    logic [CENTER_W-1:0]       cx_reg, cx_next;
    logic [CENTER_W-1:0]       cy_reg, cy_next;
    logic [PIX_AW-1:0]         row_base_reg, row_base_next;
    logic [TAP_W-1:0]          iu_reg, iu_next;
    logic [TAP_W-1:0]          iv_reg, iv_next;
    logic [TAP_W-1:0]          n_reg, n_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic                      drain_reg, drain_next;
    logic                      err_reg, err_next;

    logic [8:0]                sw;
    logic [8:0]                sh;
    logic [4:0]                span;
    logic [3:0]                half;
    logic [TAP_W-1:0]          n_calc;
    logic [COORD_W-1:0]        b_calc;
    logic [8:0]                xs;
    logic [8:0]                ys;
    logic signed [COORD_W+9:0] rb_prod;
    logic                      u_in;
    logic                      v_in;
    logic                      tap_in;

    // clamped geometry
    assign sw     = (int'(cfg.src_w) > MAX_SRC_WIDTH) ? 9'(MAX_SRC_WIDTH) : cfg.src_w;
    assign sh     = (int'(cfg.src_h) > MAX_SRC_HEIGHT) ? 9'(MAX_SRC_HEIGHT) : cfg.src_h;
    assign span   = (int'(cfg.span) > MAX_SPAN) ? 5'(MAX_SPAN) : cfg.span;
    assign half   = span[4:1];
    assign n_calc = (half == 4'd0) ? '0 : TAP_W'({half, 1'b0}) - TAP_W'(1);
    assign b_calc = COORD_W'(half) - COORD_W'(1);
    assign xs     = 9'(dest_x) + 9'(cfg.margin);
    assign ys     = 9'(dest_y) + 9'(cfg.margin);

    // first row base address, taken modulo the store depth
    assign rb_prod = v_reg * $signed({1'b0, sw});

    // bounds test of the current tap
    assign u_in   = !u_reg[COORD_W-1] && (u_reg < $signed({6'b0, sw}));
    assign v_in   = !v_reg[COORD_W-1] && (v_reg < $signed({6'b0, sh}));
    assign tap_in = u_in && v_in;

    assign rd_req.en       = (state_reg == ST_SCAN) && tap_in;
    assign rd_req.pix_addr = row_base_reg + PIX_AW'(u_reg);
    assign wgt_addr        = k_reg[WA_W-1:0];

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // tap walk registers
    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        u0_reg       <= u0_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        row_base_reg <= row_base_next;
        iu_reg       <= iu_next;
        iv_reg       <= iv_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        drain_reg    <= drain_next;
        err_reg      <= err_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        u0_next       = u0_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        row_base_next = row_base_reg;
        iu_next       = iu_reg;
        iv_next       = iv_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        drain_next    = drain_reg;
        err_next      = err_reg;
        stat.idle     = 1'b0;
        stat.res_load = 1'b0;
        stat.res_err  = err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (go)
                begin
                    cx_next  = CENTER_W'({5'b0, xs} * {9'b0, cfg.factor});
                    cy_next  = CENTER_W'({5'b0, ys} * {9'b0, cfg.factor});
                    err_next = (9'(dest_x) >= cfg.dst_w) || (9'(dest_y) >= cfg.dst_h);
                    if ((9'(dest_x) >= cfg.dst_w) || (9'(dest_y) >= cfg.dst_h))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_ORIGIN;
                    end
                end
            end

            ST_ORIGIN:
            begin
                u0_next    = $signed({1'b0, cx_reg}) - $signed(b_calc);
                u_next     = $signed({1'b0, cx_reg}) - $signed(b_calc);
                v_next     = $signed({1'b0, cy_reg}) - $signed(b_calc);
                n_next     = n_calc;
                state_next = ST_ROWBASE;
            end

            ST_ROWBASE:
            begin
                row_base_next = rb_prod[PIX_AW-1:0];
                iu_next       = '0;
                iv_next       = '0;
                k_next        = '0;
                drain_next    = 1'b0;
                if (n_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                k_next = k_reg + K_W'(1);
                if (iu_reg == n_reg - TAP_W'(1))
                begin
                    iu_next       = '0;
                    u_next        = u0_reg;
                    iv_next       = iv_reg + TAP_W'(1);
                    v_next        = v_reg + COORD_W'(1);
                    row_base_next = row_base_reg + PIX_AW'(sw);
                    if (iv_reg == n_reg - TAP_W'(1))
                    begin
                        drain_next = 1'b0;
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    iu_next = iu_reg + TAP_W'(1);
                    u_next  = u_reg + COORD_W'(1);
                end
            end

            // let the read, multiply and accumulate stages empty
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    stat.res_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // tap counters stay inside the window while scanning
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (iu_reg < n_reg) && (iv_reg < n_reg))
        else $error("tap counter outside window");

    // weight index follows the raster position, out-of-bounds taps included
    a_k_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |->
            ({5'b0, iv_reg} * {5'b0, n_reg} + {5'b0, iu_reg}) == k_reg)
        else $error("weight index out of step with tap position");
`endif

endmodule
